// ----- sv/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	// default sizes
	localparam int DEF_MAX_PROCS  = 16;
	localparam int DEF_NUM_LEVELS = 4;
	localparam int DEF_TIME_WIDTH = 32;

	// register reset values
	localparam logic [2:0] RST_LEVELS       = 3'd4;
	localparam logic [7:0] RST_QUANTUM_BASE = 8'd2;
	localparam logic [7:0] RST_AGE_LIMIT    = 8'd5;

	// register map (word index)
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_LEVELS    = 2'd0;
	localparam logic [1:0] REG_QUANTUM   = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	// item opcodes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic [2:0] levels_in_use;
		logic [7:0] quantum_base;
		logic [7:0] age_limit;
	} cfg_t;

	typedef struct packed {
		logic        op;
		logic [3:0]  proc_id;
		logic [1:0]  priority_req;
		logic [15:0] burst;
	} item_t;

	typedef struct packed {
		logic        status;
		logic        slice_valid;
		logic [3:0]  slice_pid;
		logic [31:0] slice_from;
		logic [31:0] slice_end;
		logic        slice_finished;
		logic        run_valid;
		logic [3:0]  run_pid;
		logic [1:0]  run_level;
		logic [31:0] now;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic arrive;
		logic close;
		logic age_start;
		logic age_next;
		logic age_rd;
		logic age_wr;
		logic sel_rd;
		logic sel_wr;
		logic run;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic keep_running;
		logic age_elem;
		logic age_last;
		logic any_queued;
	} dp_status_t;

endpackage

// ----- sv/mlfq_if.sv -----
// ----------------------------------------------------------------------------
// mlfq_in_if / mlfq_out_if
// Valid/ready channels for scheduler items and results.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  proc_id;
	logic [1:0]  priority_req;
	logic [15:0] burst;

	modport source (output valid, op, proc_id, priority_req, burst, input ready);
	modport sink   (input valid, op, proc_id, priority_req, burst, output ready);
endinterface

interface mlfq_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        slice_valid;
	logic [3:0]  slice_pid;
	logic [31:0] slice_from;
	logic [31:0] slice_end;
	logic        slice_finished;
	logic        run_valid;
	logic [3:0]  run_pid;
	logic [1:0]  run_level;
	logic [31:0] now;

	modport source (output valid, status, slice_valid, slice_pid, slice_from, slice_end,
		slice_finished, run_valid, run_pid, run_level, now, input ready);
	modport sink   (input valid, status, slice_valid, slice_pid, slice_from, slice_end,
		slice_finished, run_valid, run_pid, run_level, now, output ready);
endinterface

// ----- sv/mlfq_ram.sv -----
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/mlfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: accepts an item, steps the datapath through arrival, or through
// close, aging, selection and run, and owns the result register handshake.
// ----------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_ARRIVE = 8'b00000010,
		S_CLOSE  = 8'b00000100,
		S_AGE_RD = 8'b00001000,
		S_AGE_WR = 8'b00010000,
		S_SEL_RD = 8'b00100000,
		S_SEL_WR = 8'b01000000,
		S_RUN    = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	// result slot can take a new item this cycle
	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = (in_op == OP_TICK) ? S_CLOSE : S_ARRIVE;
				end
			end
			S_ARRIVE: begin
				if (out_free) begin
					cmd.arrive = 1'b1;
					out_load   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				if (status.keep_running) begin
					state_d = S_RUN;
				end else begin
					cmd.age_start = 1'b1;
					state_d = S_AGE_RD;
				end
			end
			S_AGE_RD: begin
				if (status.age_elem) begin
					cmd.age_rd = 1'b1;
					state_d = S_AGE_WR;
				end else if (!status.age_last) begin
					cmd.age_next = 1'b1;
				end else begin
					state_d = S_SEL_RD;
				end
			end
			S_AGE_WR: begin
				cmd.age_wr = 1'b1;
				state_d = S_AGE_RD;
			end
			S_SEL_RD: begin
				if (status.any_queued) begin
					cmd.sel_rd = 1'b1;
					state_d = S_SEL_WR;
				end else begin
					state_d = S_RUN;
				end
			end
			S_SEL_WR: begin
				cmd.sel_wr = 1'b1;
				state_d = S_RUN;
			end
			S_RUN: begin
				if (out_free) begin
					cmd.run  = 1'b1;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/mlfq_dp.sv -----
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: level queues in RAM, per-process state, running slice, time,
// and the result register.
// ----------------------------------------------------------------------------
module mlfq_dp import mlfq_pkg::*; #(
	parameter int MAX_PROCS  = DEF_MAX_PROCS,
	parameter int NUM_LEVELS = DEF_NUM_LEVELS,
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  cfg_t       cfg,
	input  item_t      item,
	output result_t    result
);

	localparam int PW = $clog2(MAX_PROCS);
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int AW = LW + PW;
	localparam int TW = TIME_WIDTH;

	// queues
	logic [PW-1:0] head_q [NUM_LEVELS];
	logic [CW-1:0] cnt_q  [NUM_LEVELS];

	// per-process state
	logic [15:0] rem_q  [MAX_PROCS];
	logic [7:0]  wait_q [MAX_PROCS];
	logic        act_q  [MAX_PROCS];

	// running slice and time
	logic          run_valid_q;
	logic [PW-1:0] run_pid_q;
	logic [LW-1:0] run_lvl_q;
	logic [15:0]   quant_q;
	logic [TW-1:0] begin_q;
	logic [TW-1:0] time_q;

	// aging walk
	logic [LW-1:0] age_lvl_q;
	logic [CW-1:0] age_k_q;
	logic [CW-1:0] age_n_q;

	// item, closed slice of this tick, result
	item_t         item_q;
	logic          sl_valid_q;
	logic [PW-1:0] sl_pid_q;
	logic [TW-1:0] sl_start_q;
	logic [TW-1:0] sl_end_q;
	logic          sl_fin_q;
	result_t       result_q;

	// combinational
	logic [3:0]    eff_lv;
	logic [8:0]    id9;
	logic          id_ok;
	logic [PW-1:0] a_idx;
	logic          reject;
	logic [3:0]    a_lvl4;
	logic          higher;
	logic          rem_zero;
	logic          closing;
	logic [LW-1:0] demote_lvl;
	logic          sel_any;
	logic [LW-1:0] sel_lvl;
	logic [PW-1:0] rd_pid;
	logic          promote;
	logic          push_en;
	logic [LW-1:0] push_lvl;
	logic [PW-1:0] push_pid;
	logic          pop_en;
	logic [LW-1:0] pop_lvl;
	logic [PW-1:0] tail;
	logic [7:0]    bq;
	logic [TW-1:0] time_inc;

	function automatic logic [31:0] to32(input logic [TW-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[31:0];
	endfunction

	function automatic logic [3:0] pid4(input logic [PW-1:0] v);
		logic [8:0] t;
		t = 9'(v);
		return t[3:0];
	endfunction

	function automatic logic [1:0] lvl2(input logic [LW-1:0] v);
		logic [3:0] t;
		t = 4'(v);
		return t[1:0];
	endfunction

	// wrap an index that runs past the last process back into the table
	function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
		logic [PW:0] t;
		t = (v >= (PW+1)'(MAX_PROCS)) ? v - (PW+1)'(MAX_PROCS) : v;
		return t[PW-1:0];
	endfunction

	// effective level count
	always_comb begin
		if (cfg.levels_in_use == 3'd0) begin
			eff_lv = 4'd1;
		end else if (4'(cfg.levels_in_use) > 4'(NUM_LEVELS)) begin
			eff_lv = 4'(NUM_LEVELS);
		end else begin
			eff_lv = 4'(cfg.levels_in_use);
		end
	end

	// arrival checks and level clamp
	assign id9    = 9'(item_q.proc_id);
	assign id_ok  = id9 < 9'(MAX_PROCS);
	assign a_idx  = id9[PW-1:0];
	assign reject = !id_ok || act_q[a_idx] || (item_q.burst == 16'd0);
	assign a_lvl4 = (4'(item_q.priority_req) < eff_lv - 4'd1) ?
		4'(item_q.priority_req) : eff_lv - 4'd1;

	// slice close decision
	always_comb begin
		higher = 1'b0;
		for (int p = 0; p < NUM_LEVELS; p++) begin
			if (LW'(p) < run_lvl_q && cnt_q[p] != '0) begin
				higher = 1'b1;
			end
		end
	end
	assign rem_zero   = rem_q[run_pid_q] == 16'd0;
	assign closing    = run_valid_q && (rem_zero || higher || quant_q == 16'd0);
	assign demote_lvl = (4'(run_lvl_q) + 4'd1 < eff_lv) ? run_lvl_q + 1'b1 : run_lvl_q;

	// highest nonempty level
	always_comb begin
		sel_any = 1'b0;
		sel_lvl = '0;
		for (int p = NUM_LEVELS - 1; p >= 0; p--) begin
			if (cnt_q[p] != '0) begin
				sel_any = 1'b1;
				sel_lvl = LW'(p);
			end
		end
	end

	assign promote = wait_q[rd_pid] >= cfg.age_limit;
	assign bq      = (cfg.quantum_base == 8'd0) ? 8'd1 : cfg.quantum_base;

	// queue write side
	always_comb begin
		push_en  = 1'b0;
		push_lvl = '0;
		push_pid = '0;
		if (cmd.arrive && !reject) begin
			push_en  = 1'b1;
			push_lvl = LW'(a_lvl4);
			push_pid = a_idx;
		end else if (cmd.close && closing && !rem_zero) begin
			push_en  = 1'b1;
			push_lvl = higher ? run_lvl_q : demote_lvl;
			push_pid = run_pid_q;
		end else if (cmd.age_wr) begin
			push_en  = 1'b1;
			push_lvl = promote ? age_lvl_q - 1'b1 : age_lvl_q;
			push_pid = rd_pid;
		end
	end

	// queue read side
	always_comb begin
		pop_en  = 1'b0;
		pop_lvl = '0;
		if (cmd.age_rd) begin
			pop_en  = 1'b1;
			pop_lvl = age_lvl_q;
		end else if (cmd.sel_rd) begin
			pop_en  = 1'b1;
			pop_lvl = sel_lvl;
		end
	end

	assign tail = wrap({1'b0, head_q[push_lvl]} + (PW+1)'(cnt_q[push_lvl]));

	mlfq_ram #(
		.WIDTH(PW),
		.DEPTH(1 << AW)
	) u_queue_ram (
		.clk  (clk),
		.we   (push_en),
		.waddr({push_lvl, tail}),
		.wdata(push_pid),
		.raddr({pop_lvl, head_q[pop_lvl]}),
		.rdata(rd_pid)
	);

	// queue heads and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				if (pop_en && pop_lvl == LW'(l)) begin
					head_q[l] <= wrap({1'b0, head_q[l]} + 1'b1);
				end
				cnt_q[l] <= cnt_q[l] + CW'(push_en && push_lvl == LW'(l))
					- CW'(pop_en && pop_lvl == LW'(l));
			end
		end
	end

	assign time_inc = time_q + 1'b1;

	// process, slice, aging and time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PROCS; j++) begin
				wait_q[j] <= '0;
				act_q[j]  <= 1'b0;
			end
			run_valid_q <= 1'b0;
			run_pid_q   <= '0;
			run_lvl_q   <= '0;
			quant_q     <= '0;
			begin_q     <= '0;
			time_q      <= '0;
			age_lvl_q   <= '0;
			age_k_q     <= '0;
			age_n_q     <= '0;
		end else begin
			// arrival
			if (cmd.arrive && !reject) begin
				wait_q[a_idx] <= '0;
				act_q[a_idx]  <= 1'b1;
			end
			// close
			if (cmd.close && closing) begin
				wait_q[run_pid_q] <= '0;
				run_valid_q <= 1'b0;
				if (rem_zero) begin
					act_q[run_pid_q] <= 1'b0;
				end
			end
			// aging walk
			if (cmd.age_start) begin
				age_lvl_q <= '0;
				age_k_q   <= '0;
				age_n_q   <= '0;
			end
			if (cmd.age_next) begin
				age_lvl_q <= age_lvl_q + 1'b1;
				age_k_q   <= '0;
				age_n_q   <= cnt_q[LW'(age_lvl_q + 1'b1)];
			end
			if (cmd.age_rd) begin
				age_k_q <= age_k_q + 1'b1;
			end
			if (cmd.age_wr && promote) begin
				wait_q[rd_pid] <= '0;
			end
			// select
			if (cmd.sel_rd) begin
				run_lvl_q <= sel_lvl;
				quant_q   <= 16'({8'd0, bq} << sel_lvl);
				begin_q   <= time_q;
			end
			if (cmd.sel_wr) begin
				run_pid_q   <= rd_pid;
				run_valid_q <= 1'b1;
			end
			// one time unit
			if (cmd.run) begin
				time_q <= time_inc;
				if (run_valid_q) begin
					if (quant_q != 16'd0) begin
						quant_q <= quant_q - 16'd1;
					end
					for (int j = 0; j < MAX_PROCS; j++) begin
						if (act_q[j] && PW'(j) != run_pid_q && wait_q[j] != 8'hFF) begin
							wait_q[j] <= wait_q[j] + 8'd1;
						end
					end
				end
			end
		end
	end

	// remaining time, item, slice record, result
	always_ff @(posedge clk) begin
		if (cmd.arrive && !reject) begin
			rem_q[a_idx] <= item_q.burst;
		end
		if (cmd.run && run_valid_q && !rem_zero) begin
			rem_q[run_pid_q] <= rem_q[run_pid_q] - 16'd1;
		end
		if (cmd.load_in) begin
			item_q     <= item;
			sl_valid_q <= 1'b0;
		end
		if (cmd.close && closing) begin
			sl_valid_q <= 1'b1;
			sl_pid_q   <= run_pid_q;
			sl_start_q <= begin_q;
			sl_end_q   <= time_q;
			sl_fin_q   <= rem_zero;
		end
		if (cmd.arrive) begin
			result_q.status         <= reject;
			result_q.slice_valid    <= 1'b0;
			result_q.slice_pid      <= 4'd0;
			result_q.slice_from     <= 32'd0;
			result_q.slice_end      <= 32'd0;
			result_q.slice_finished <= 1'b0;
			result_q.run_valid      <= 1'b0;
			result_q.run_pid        <= 4'd0;
			result_q.run_level      <= 2'd0;
			result_q.now            <= to32(time_q);
		end
		if (cmd.run) begin
			result_q.status         <= 1'b0;
			result_q.slice_valid    <= sl_valid_q;
			result_q.slice_pid      <= sl_valid_q ? pid4(sl_pid_q) : 4'd0;
			result_q.slice_from     <= sl_valid_q ? to32(sl_start_q) : 32'd0;
			result_q.slice_end      <= sl_valid_q ? to32(sl_end_q) : 32'd0;
			result_q.slice_finished <= sl_valid_q && sl_fin_q;
			result_q.run_valid      <= run_valid_q;
			result_q.run_pid        <= run_valid_q ? pid4(run_pid_q) : 4'd0;
			result_q.run_level      <= run_valid_q ? lvl2(run_lvl_q) : 2'd0;
			result_q.now            <= to32(time_inc);
		end
	end

	assign result = result_q;

	assign status.keep_running = run_valid_q && !closing;
	assign status.age_elem     = age_k_q != age_n_q;
	assign status.age_last     = age_lvl_q == LW'(NUM_LEVELS - 1);
	assign status.any_queued   = sel_any;

	// occupancy: queued plus running never exceeds the process table
	logic [CW+3:0] q_total;
	always_comb begin
		q_total = (CW+4)'(run_valid_q);
		for (int l = 0; l < NUM_LEVELS; l++) begin
			q_total = q_total + (CW+4)'(cnt_q[l]);
		end
	end

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		q_total <= (CW+4)'(MAX_PROCS))
		else $error("queued and running processes exceed the process table");

	a_running_active: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> act_q[run_pid_q])
		else $error("running process is not present");

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |=> time_q == TW'($past(time_q) + 1'b1))
		else $error("time did not advance by one on a tick");

	a_age_level: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.age_wr |-> age_lvl_q != '0)
		else $error("aging write-back on the top level");

endmodule

// ----- sv/mlfq_scheduler_with_aging_core.sv -----
// ----------------------------------------------------------------------------
// mlfq_scheduler_with_aging_core
// Multilevel feedback queue scheduler with aging, APB configuration.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An arrival passes through the arrive
// state. A tick whose running slice stays open goes from close straight to
// run. Any other tick runs the aging walk over the waiters on levels 1 and
// below after the running slice closes, then a selection read and write-back
// when a queued process is picked to run;
// the walk rotates each waiter through the queue RAM with a read and a
// write-back. The result register lets the next item be accepted
// while a result waits; work stalls only when that register is still full.
// Registers: 0x0 levels_in_use, 0x4 quantum base, 0x8 age limit.
// ----------------------------------------------------------------------------
module mlfq_scheduler_with_aging_core import mlfq_pkg::*; #(
	parameter int MAX_PROCS  = DEF_MAX_PROCS,
	parameter int NUM_LEVELS = DEF_NUM_LEVELS,
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	mlfq_in_if.sink           request,
	mlfq_out_if.source        response,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg_q;
	item_t      item;
	result_t    result;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       wr_en;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.levels_in_use <= RST_LEVELS;
			cfg_q.quantum_base  <= RST_QUANTUM_BASE;
			cfg_q.age_limit     <= RST_AGE_LIMIT;
		end else if (wr_en && paddr[1:0] == 2'd0) begin
			unique case (paddr[3:2])
				REG_LEVELS:    cfg_q.levels_in_use <= pwdata[2:0];
				REG_QUANTUM:   cfg_q.quantum_base  <= pwdata[7:0];
				REG_THRESHOLD: cfg_q.age_limit     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_LEVELS:    prdata = {29'd0, cfg_q.levels_in_use};
			REG_QUANTUM:   prdata = {24'd0, cfg_q.quantum_base};
			REG_THRESHOLD: prdata = {24'd0, cfg_q.age_limit};
			default:       prdata = 32'd0;
		endcase
	end

	assign item.op           = request.op;
	assign item.proc_id      = request.proc_id;
	assign item.priority_req = request.priority_req;
	assign item.burst        = request.burst;

	mlfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_op    (request.op),
		.in_ready (request.ready),
		.out_valid(response.valid),
		.out_ready(response.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mlfq_dp #(
		.MAX_PROCS (MAX_PROCS),
		.NUM_LEVELS(NUM_LEVELS),
		.TIME_WIDTH(TIME_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.status(status),
		.cfg   (cfg_q),
		.item  (item),
		.result(result)
	);

	assign response.status         = result.status;
	assign response.slice_valid    = result.slice_valid;
	assign response.slice_pid      = result.slice_pid;
	assign response.slice_from     = result.slice_from;
	assign response.slice_end      = result.slice_end;
	assign response.slice_finished = result.slice_finished;
	assign response.run_valid      = result.run_valid;
	assign response.run_pid        = result.run_pid;
	assign response.run_level      = result.run_level;
	assign response.now            = result.now;

endmodule
